// ===== rtl/sdnv_pkg.sv =====
// shared constants for the sdnv encoder
`timescale 1ns / 1ps
package sdnv_pkg;

  localparam int VALUE_BITS = 64;
  localparam int MAX_BYTES  = 16;
  localparam int GROUP_W    = 7;
  localparam int CNT_W      = $clog2(MAX_BYTES + 1);
  localparam int IDX_W      = $clog2(MAX_BYTES);

  localparam int VALUE_W    = 64;
  localparam int WIDTH_W    = 5;
  localparam int ROOM_W     = 16;
  localparam int BYTE_W     = 8;
  localparam int IN_BITS    = VALUE_W + WIDTH_W + ROOM_W;
  localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = BYTE_W + 2 + WIDTH_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [ROOM_W-1:0] MAX_BYTES_ROOM = ROOM_W'(MAX_BYTES);
  localparam logic [BYTE_W-1:0] MORE_BIT       = 8'h80;

endpackage

// ===== rtl/sdnv_encoder_unit.sv =====
// sdnv encoder top level: group splitter and byte emitter under one sequencer
//
//   port group   dir  handshake        payload
//   s_axis       in   tvalid/tready    value, fixed_width, room
//   m_axis       out  tvalid/tready    out_byte, flags, byte_count; tuser byte_valid
//
// one 7-bit shift step per cycle splits the value into groups, low group first,
// until the width cut to the room is reached, or for width 0 until the rest is zero;
// then, while the output is not stalled, one byte per cycle is emitted most significant group first
// zero room skips the split and emits one flag-only result
// rst_ni clears the sequencer and the output valid
// input ready only in idle; a stalled output holds the emitter
`timescale 1ns / 1ps
module sdnv_encoder_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // value[63:0], fixed_width[68:64], room[84:69], zero pad
  input  logic [sdnv_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // out_byte[7:0], overflow[8], incomplete[9], byte_count[14:10], zero pad
  output logic [sdnv_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o,
  // byte_valid[0]
  output logic                                 m_axis_tuser_o,
  output logic                                 m_axis_tlast_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SPLIT = 3'b010,
    ST_EMIT  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [sdnv_pkg::VALUE_BITS-1:0] res_q, res_d, res_shift;
  logic [sdnv_pkg::CNT_W-1:0]      k_q, k_d, k_inc;
  logic [sdnv_pkg::CNT_W-1:0]      lim_q, lim_d;
  logic [sdnv_pkg::CNT_W-1:0]      cnt_q, cnt_d;
  logic [sdnv_pkg::IDX_W-1:0]      idx_q, idx_d;
  logic                            req0_q, req0_d;
  logic                            cut_q, cut_d;
  logic                            ovf_q, ovf_d;
  logic                            zero_q, zero_d;

  logic [sdnv_pkg::GROUP_W-1:0]    grp_q [sdnv_pkg::MAX_BYTES];
  logic                            grp_we;

  logic                            m_valid_q, m_valid_d;
  logic [sdnv_pkg::BYTE_W-1:0]     m_byte_q, m_byte_d;
  logic                            m_bvalid_q, m_bvalid_d;
  logic                            m_last_q, m_last_d;
  logic                            m_ovf_q, m_ovf_d;
  logic                            m_cut_q, m_cut_d;
  logic [sdnv_pkg::WIDTH_W-1:0]    m_cnt_q, m_cnt_d;

  logic [sdnv_pkg::VALUE_W-1:0]    in_value;
  logic [sdnv_pkg::WIDTH_W-1:0]    in_width;
  logic [sdnv_pkg::ROOM_W-1:0]     in_room;
  logic [sdnv_pkg::ROOM_W-1:0]     width_req, width_lim;
  logic                            in_req0;
  logic                            s_fire, out_free, split_done;

  assign in_value = s_axis_tdata_i[sdnv_pkg::VALUE_W-1:0];
  assign in_width = s_axis_tdata_i[sdnv_pkg::VALUE_W +: sdnv_pkg::WIDTH_W];
  assign in_room  = s_axis_tdata_i[sdnv_pkg::VALUE_W + sdnv_pkg::WIDTH_W +: sdnv_pkg::ROOM_W];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;

  // requested width, saturated, then cut to the room
  assign in_req0   = (in_width == '0);
  assign width_req = (in_req0 || (sdnv_pkg::ROOM_W'(in_width) > sdnv_pkg::MAX_BYTES_ROOM))
                     ? sdnv_pkg::MAX_BYTES_ROOM : sdnv_pkg::ROOM_W'(in_width);
  assign width_lim = (width_req > in_room) ? in_room : width_req;

  // shared shift unit
  assign res_shift  = res_q >> sdnv_pkg::GROUP_W;
  assign k_inc      = k_q + sdnv_pkg::CNT_W'(1);
  assign split_done = (k_inc == lim_q) || (req0_q && (res_shift == '0));
  assign grp_we     = (state_q == ST_SPLIT);

  always_comb begin
    state_d    = state_q;
    res_d      = res_q;
    k_d        = k_q;
    lim_d      = lim_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    req0_d     = req0_q;
    cut_d      = cut_q;
    ovf_d      = ovf_q;
    zero_d     = zero_q;
    m_valid_d  = m_valid_q && !m_axis_tready_i;
    m_byte_d   = m_byte_q;
    m_bvalid_d = m_bvalid_q;
    m_last_d   = m_last_q;
    m_ovf_d    = m_ovf_q;
    m_cut_d    = m_cut_q;
    m_cnt_d    = m_cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          res_d  = in_value[sdnv_pkg::VALUE_BITS-1:0];
          k_d    = '0;
          lim_d  = sdnv_pkg::CNT_W'(width_lim);
          req0_d = in_req0;
          cut_d  = !in_req0 && (width_req > in_room);
          zero_d = (in_room == '0);
          if (in_room == '0) begin
            cut_d   = 1'b1;
            ovf_d   = (in_value[sdnv_pkg::VALUE_BITS-1:0] != '0);
            cnt_d   = '0;
            state_d = ST_EMIT;
          end else begin
            state_d = ST_SPLIT;
          end
        end
      end
      ST_SPLIT: begin
        res_d = res_shift;
        k_d   = k_inc;
        if (split_done) begin
          ovf_d   = (res_shift != '0);
          cut_d   = req0_q ? (res_shift != '0) : cut_q;
          cnt_d   = k_inc;
          idx_d   = k_q[sdnv_pkg::IDX_W-1:0];
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_ovf_d   = ovf_q;
          m_cut_d   = cut_q;
          m_cnt_d   = sdnv_pkg::WIDTH_W'(cnt_q);
          if (zero_q) begin
            m_byte_d   = '0;
            m_bvalid_d = 1'b0;
            m_last_d   = 1'b1;
            state_d    = ST_IDLE;
          end else begin
            m_byte_d   = {(idx_q != '0), grp_q[idx_q]};
            m_bvalid_d = 1'b1;
            m_last_d   = (idx_q == '0);
            if (idx_q == '0) begin
              state_d = ST_IDLE;
            end else begin
              idx_d = idx_q - sdnv_pkg::IDX_W'(1);
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
      k_q       <= '0;
      lim_q     <= '0;
      cnt_q     <= '0;
      idx_q     <= '0;
      req0_q    <= 1'b0;
      cut_q     <= 1'b0;
      ovf_q     <= 1'b0;
      zero_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      k_q       <= k_d;
      lim_q     <= lim_d;
      cnt_q     <= cnt_d;
      idx_q     <= idx_d;
      req0_q    <= req0_d;
      cut_q     <= cut_d;
      ovf_q     <= ovf_d;
      zero_q    <= zero_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q      <= res_d;
    m_byte_q   <= m_byte_d;
    m_bvalid_q <= m_bvalid_d;
    m_last_q   <= m_last_d;
    m_ovf_q    <= m_ovf_d;
    m_cut_q    <= m_cut_d;
    m_cnt_q    <= m_cnt_d;
  end

  // group store, low group at entry 0
  always_ff @(posedge clk_i) begin
    if (grp_we) begin
      grp_q[k_q[sdnv_pkg::IDX_W-1:0]] <= res_q[sdnv_pkg::GROUP_W-1:0];
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_bvalid_q;
  assign m_axis_tlast_o  = m_last_q;
  assign m_axis_tdata_o  = sdnv_pkg::OUT_TDATA_W'({m_cnt_q, m_cut_q, m_ovf_q, m_byte_q});

  // split never runs past the limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SPLIT) |-> (k_q < lim_q))
    else $error("split index beyond width limit");

  // emit index stays inside the written groups
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && !zero_q) |-> (sdnv_pkg::CNT_W'(idx_q) < cnt_q))
    else $error("emit index beyond byte count");

  // flag-only result has no bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tlast_o && m_cnt_q == '0))
    else $error("flag-only result malformed");

  // continuation bit clear exactly on the final byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_byte_q[7] == !m_axis_tlast_o))
    else $error("continuation bit mismatch");

  // the split sets up a fresh emit run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SPLIT && split_done) |=> (state_q == ST_EMIT && cnt_q != '0))
    else $error("split did not hand over to emit");

endmodule
